/* rtl/core/cubic_interpolated_delay_line_unit_assert.svh */
// Assertion macros for the cubic interpolated delay line unit.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef CUBIC_INTERPOLATED_DELAY_LINE_UNIT_ASSERT_SVH
`define CUBIC_INTERPOLATED_DELAY_LINE_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define CIDL_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define CIDL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cidl_pkg.sv */
// Package for the cubic interpolated delay line unit: sizes, codes, constants.
// No dependencies.
`default_nettype none

package cidl_pkg;

  localparam int unsigned Rows     = 1024;
  localparam int unsigned Channels = 16;
  localparam int unsigned RowW     = $clog2(Rows);
  localparam int unsigned ChW      = $clog2(Channels);
  localparam int unsigned AddrW    = RowW + ChW;
  localparam int unsigned LenW     = RowW + 1;

  localparam logic [LenW-1:0] MinLen = LenW'(4);
  localparam logic [LenW-1:0] MaxLen = LenW'(Rows);

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    CFG_STEP_RATE = 2'd0,
    CFG_DELAY_LIM = 2'd1,
    CFG_RING_LEN  = 2'd2,
    CFG_STORE_EN  = 2'd3
  } cfg_idx_e;

  // Item kinds.
  typedef enum logic [1:0] {
    MODE_ADVANCE = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  // ceil(2^33 / 3): floor(y * Recip3 >> 33) == floor(y / 3) for 32-bit y.
  localparam logic [31:0] Recip3 = 32'hAAAA_AAAB;

  localparam logic [16:0] OneQ16 = 17'h1_0000;

endpackage

`default_nettype wire

/* rtl/core/cubic_interpolated_delay_line_unit.sv */
// Cubic interpolated delay line unit: history ring memory, serial modulo unit,
// Lagrange weight generator and a tap accumulator. Uses cidl_pkg and the
// assertion macro header.
//
// Reset: asynchronous, active low. After reset the history memory is cleared
// by a pass over all 16384 entries, one entry per cycle; no item is accepted until it
// ends, configuration writes are taken throughout.
// Steps per item: advance and write run a 10-step remainder of the newest row
// by the ring length, then a dispatch state. A read runs the 10 steps for the
// newest row, the dispatch state, 32 steps for the integer delay modulo the
// ring length, a state for the first tap row, weight generation (per tap a
// product, a rounding that divides the outer taps by three, and a set state),
// the four taps on the single memory read port, a rounding state and a move
// into the output register. Reads that hit the range check go from dispatch
// to the output state, zero-delay reads through a memory read and a wait state.
// A read waits in the output state while the output register stays full.
// Throughput: one item at a time; the next item is taken while a finished
// result still sits in the output register.
`default_nettype none

module cubic_interpolated_delay_line_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // channel[3:0], sample_value[35:4],
                                           // delay_time[67:36], zero fill
  input  wire logic [1:0]  s_axis_tuser,   // mode[1:0]
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // delayed_value[31:0]
  output logic             m_axis_tuser,   // range_error[0]
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned RowW  = cidl_pkg::RowW;
  localparam int unsigned ChW   = cidl_pkg::ChW;
  localparam int unsigned AddrW = cidl_pkg::AddrW;
  localparam int unsigned LenW  = cidl_pkg::LenW;
  localparam int unsigned Depth = cidl_pkg::Rows * cidl_pkg::Channels;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_TOPMOD, ST_DISPATCH, ST_NMOD, ST_BASE,
    ST_WMUL, ST_WRND, ST_WSET, ST_TRD, ST_TMUL, ST_TACC, ST_FIN,
    ST_ZRD, ST_ZWAIT, ST_OUT
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0]     step_rate_q, delay_lim_q;
  logic [LenW-1:0] ring_len_q;
  logic            store_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_rate_q <= 32'd65536;
      delay_lim_q <= 32'd67108864;
      ring_len_q  <= cidl_pkg::MaxLen;
      store_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cidl_pkg::cfg_idx_e'(cfg_idx_i))
        cidl_pkg::CFG_STEP_RATE: step_rate_q <= cfg_wdata_i;
        cidl_pkg::CFG_DELAY_LIM: delay_lim_q <= cfg_wdata_i;
        cidl_pkg::CFG_RING_LEN:  ring_len_q  <= cfg_wdata_i[LenW-1:0];
        cidl_pkg::CFG_STORE_EN:  store_en_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Ring length in use, clamped to the legal range.
  logic [LenW-1:0] len_use;
  always_comb begin
    if (ring_len_q < cidl_pkg::MinLen)      len_use = cidl_pkg::MinLen;
    else if (ring_len_q > cidl_pkg::MaxLen) len_use = cidl_pkg::MaxLen;
    else                                    len_use = ring_len_q;
  end

  // ---------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------
  state_e                 state_q;
  logic [AddrW-1:0]       clr_q;
  cidl_pkg::mode_e        mode_q;
  logic [ChW-1:0]         ch_q;
  logic [31:0]            sample_q, delay_q;
  logic [63:0]            p_q;
  logic [LenW-1:0]        rem_q;
  logic [31:0]            div_q;
  logic [5:0]             cnt_q;
  logic [RowW-1:0]        newest_q, top_q, base_q;
  logic [15:0]            u_q;
  logic [33:0]            bc_q;
  logic [32:0]            eu_q;
  logic [50:0]            m_q;
  logic [31:0]            sh_q;
  logic [63:0]            dv_q;
  logic [1:0]             k_q;
  logic signed [31:0]     w_q [4];
  logic signed [63:0]     prod_q, acc_q;
  logic [31:0]            res_q;
  logic                   err_q;
  logic                   m_valid_q;
  logic [31:0]            m_data_q;
  logic                   m_user_q;

  // ---------------------------------------------------------------------------
  // History memory: one write port, one read port with registered data
  // ---------------------------------------------------------------------------
  logic [31:0]        mem [Depth];
  logic               mem_we;
  logic [AddrW-1:0]   mem_wa, mem_ra;
  logic [31:0]        mem_wd;
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[mem_ra];
  end

  // ---------------------------------------------------------------------------
  // Serial remainder step: shift in one dividend bit, subtract the length
  // ---------------------------------------------------------------------------
  logic [LenW:0]   rem_t;
  logic [LenW-1:0] rem_step;
  always_comb begin
    rem_t    = {rem_q, div_q[31]};
    rem_step = (rem_t >= {1'b0, len_use}) ? LenW'(rem_t - {1'b0, len_use})
                                          : rem_t[LenW-1:0];
  end

  // First tap row: top + (n mod L) + L - 1, reduced below L.
  logic [LenW:0] base_sum, len_x2;
  logic [RowW-1:0] base_d;
  always_comb begin
    base_sum = {2'b0, top_q} + {1'b0, rem_q} + {1'b0, len_use} - (LenW+1)'(1);
    len_x2   = {len_use, 1'b0};
    if (base_sum >= len_x2)                base_d = RowW'(base_sum - len_x2);
    else if (base_sum >= {1'b0, len_use}) base_d = RowW'(base_sum - {1'b0, len_use});
    else                                   base_d = base_sum[RowW-1:0];
  end

  // Row of tap k, wrapped once.
  logic [LenW-1:0] row_sum;
  logic [RowW-1:0] row_k;
  always_comb begin
    row_sum = {1'b0, base_q} + LenW'(k_q);
    row_k   = (row_sum >= len_use) ? RowW'(row_sum - len_use) : row_sum[RowW-1:0];
  end

  // Lagrange factors with u in [0, 1): b = 1-u, c = 2-u, e = 1+u (Q16).
  logic [16:0] fac_b, fac_e;
  logic [17:0] fac_c;
  always_comb begin
    fac_b = cidl_pkg::OneQ16 - {1'b0, u_q};
    fac_e = cidl_pkg::OneQ16 + {1'b0, u_q};
    fac_c = {cidl_pkg::OneQ16, 1'b0} - {2'b0, u_q};
  end

  // Weight magnitudes, up to a common scale: 3*|W0| = u*b*c, |W1| = e*b*c,
  // |W2| = e*u*c, 3*|W3| = e*u*b. W0 and W3 are negative, W1 and W2 positive.
  logic [50:0] mag_d;
  always_comb begin
    case (k_q)
      2'd0:    mag_d = 51'(u_q) * 51'(bc_q);
      2'd1:    mag_d = 51'(fac_e) * 51'(bc_q);
      2'd2:    mag_d = 51'(fac_c) * 51'(eu_q);
      default: mag_d = 51'(fac_b) * 51'(eu_q);
    endcase
  end

  // Round half away from zero at 2^19, or at 6 * 2^18 for the outer taps, which divide by three.
  logic [50:0] sh_sum, dv_sum;
  logic [31:0] dv_in;
  always_comb begin
    sh_sum = m_q + 51'(1 << 18);
    dv_sum = m_q + 51'(3 << 18);
    dv_in  = dv_sum[50:19];
  end

  logic signed [31:0] w_new;
  always_comb begin
    if (k_q == 2'd0 || k_q == 2'd3) w_new = -$signed({1'b0, dv_q[63:33]});
    else                            w_new = $signed(sh_sum[50:19]);
  end

  // Final rounding at 2^30 and saturation to 32 bits.
  logic signed [63:0] acc_rnd;
  logic signed [33:0] q_full;
  logic [31:0]        q_sat;
  always_comb begin
    acc_rnd = acc_q + 64'sd536870912;
    q_full  = acc_rnd[63:30];
    if (q_full > 34'sd2147483647)       q_sat = 32'h7FFF_FFFF;
    else if (q_full < -34'sd2147483648) q_sat = 32'h8000_0000;
    else                                q_sat = q_full[31:0];
  end

  // Memory port steering.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_q == ST_DISPATCH && mode_q == cidl_pkg::MODE_WRITE && store_en_q) begin
      mem_we = 1'b1;
      mem_wa = {rem_q[RowW-1:0], ch_q};
      mem_wd = sample_q;
    end
    mem_ra = (state_q == ST_ZRD) ? {top_q, ch_q} : {row_k, ch_q};
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  logic in_xfer, out_free;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      newest_q  <= RowW'(1);
      cnt_q     <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // Drop the output after its transfer unless a new result refills it.
      if (m_valid_q && m_axis_tready && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == AddrW'(Depth - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_xfer) begin
            mode_q   <= cidl_pkg::mode_e'(s_axis_tuser);
            ch_q     <= s_axis_tdata[3:0];
            sample_q <= s_axis_tdata[35:4];
            delay_q  <= s_axis_tdata[67:36];
            p_q      <= s_axis_tdata[67:36] * step_rate_q;
            div_q    <= {newest_q, (32-RowW)'(0)};
            rem_q    <= '0;
            cnt_q    <= 6'(RowW);
            state_q  <= ST_TOPMOD;
          end
        end
        ST_TOPMOD: begin
          rem_q <= rem_step;
          div_q <= {div_q[30:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          top_q <= rem_q[RowW-1:0];
          unique case (mode_q)
            cidl_pkg::MODE_ADVANCE: begin
              if (store_en_q) begin
                newest_q <= (rem_q == '0) ? RowW'(len_use - LenW'(1))
                                          : RowW'(rem_q - LenW'(1));
              end
              state_q <= ST_IDLE;
            end
            cidl_pkg::MODE_READ: begin
              if (delay_q > delay_lim_q) begin
                res_q   <= '0;
                err_q   <= 1'b1;
                state_q <= ST_OUT;
              end else if (delay_q == '0) begin
                state_q <= ST_ZRD;
              end else begin
                div_q   <= p_q[63:32];
                rem_q   <= '0;
                cnt_q   <= 6'd32;
                u_q     <= p_q[31:16];
                state_q <= ST_NMOD;
              end
            end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_NMOD: begin
          rem_q <= rem_step;
          div_q <= {div_q[30:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_q <= ST_BASE;
        end
        ST_BASE: begin
          base_q  <= base_d;
          bc_q    <= fac_b * fac_c;
          eu_q    <= fac_e * u_q;
          k_q     <= '0;
          acc_q   <= '0;
          state_q <= ST_WMUL;
        end
        ST_WMUL: begin
          m_q     <= mag_d;
          state_q <= ST_WRND;
        end
        ST_WRND: begin
          dv_q    <= dv_in * cidl_pkg::Recip3;
          sh_q    <= sh_sum[50:19];
          state_q <= ST_WSET;
        end
        ST_WSET: begin
          w_q[k_q] <= (k_q == 2'd0 || k_q == 2'd3) ? w_new : $signed(sh_q);
          k_q      <= k_q + 2'd1;
          state_q  <= (k_q == 2'd3) ? ST_TRD : ST_WMUL;
        end
        ST_TRD: begin
          state_q <= ST_TMUL;
        end
        ST_TMUL: begin
          prod_q  <= w_q[k_q] * rdata_q;
          state_q <= ST_TACC;
        end
        ST_TACC: begin
          acc_q   <= acc_q + prod_q;
          k_q     <= k_q + 2'd1;
          state_q <= (k_q == 2'd3) ? ST_FIN : ST_TRD;
        end
        ST_FIN: begin
          res_q   <= q_sat;
          err_q   <= 1'b0;
          state_q <= ST_OUT;
        end
        ST_ZRD: begin
          state_q <= ST_ZWAIT;
        end
        ST_ZWAIT: begin
          res_q   <= rdata_q;
          err_q   <= 1'b0;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= res_q;
            m_user_q  <= err_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic signed [33:0] w_sum;
  assign w_sum = 34'(w_q[0]) + 34'(w_q[1]) + 34'(w_q[2]) + 34'(w_q[3]);

`include "cubic_interpolated_delay_line_unit_assert.svh"

  `CIDL_ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0,
    "range error result carries a nonzero value")
  `CIDL_ASSERT_IMPL(a_weight_sum, state_q == ST_TRD,
    w_sum >= 34'sd1073741822 && w_sum <= 34'sd1073741826,
    "Lagrange weights do not sum to one")
  `CIDL_ASSERT_IMPL(a_rows_in_ring, state_q == ST_TRD,
    LenW'(base_q) < len_use && LenW'(top_q) < len_use, "tap row outside the ring")

endmodule

`default_nettype wire
